/* rtl/core/wsm_pkg.sv */
// Shared constants, codes and types of the wildcard string matcher.
// No dependencies; imported by wsm_cell and wildcard_string_matcher.
package wsm_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int IDX_W       = $clog2(PATTERN_MAX);
  localparam int SYM_W       = 5;
  localparam int LEN_W       = 7;
  localparam int COUNT_W     = 21;
  localparam int KIND_W      = 2;

  localparam logic [COUNT_W-1:0] TEXT_MAX    = COUNT_W'(1048576);
  localparam logic [SYM_W-1:0]   SYM_WILD    = '0;
  localparam logic [LEN_W-1:0]   LEN_MAX     = LEN_W'(PATTERN_MAX);
  localparam logic [LEN_W-1:0]   LEN_MIN     = LEN_W'(1);

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 24;

  localparam logic [KIND_W-1:0] KIND_PATTERN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  // Controls broadcast to every cell of the chain.
  typedef struct packed {
    logic text_load;    // shift window, copy new window into probe
    logic probe_shift;  // move probe one cell toward cell 0
  } cell_ctrl_t;

endpackage

/* rtl/core/wsm_cell.sv */
// One cell of the compare chain: pattern symbol, window symbol and probe symbol.
// Depends on wsm_pkg.
module wsm_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  wsm_pkg::cell_ctrl_t       ctrl,
  input  logic                      pat_we,
  input  logic [wsm_pkg::SYM_W-1:0] pat_wdata,
  input  logic [wsm_pkg::SYM_W-1:0] win_in,
  output logic [wsm_pkg::SYM_W-1:0] win_out,
  input  logic [wsm_pkg::SYM_W-1:0] probe_in,
  output logic [wsm_pkg::SYM_W-1:0] probe_out,
  input  logic                      active,
  output logic                      hit
);
  import wsm_pkg::*;

  logic [SYM_W-1:0] pat;
  logic [SYM_W-1:0] win;
  logic [SYM_W-1:0] probe;

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat <= pat_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (ctrl.text_load) begin
      win <= win_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.text_load) begin
      probe <= win_in;
    end else if (ctrl.probe_shift) begin
      probe <= probe_in;
    end
  end

  assign win_out   = win;
  assign probe_out = probe;
  assign hit = !active || (pat == SYM_WILD) || (probe == SYM_WILD) || (pat == probe);

endmodule

/* rtl/core/wildcard_string_matcher.sv */
// Top level of the wildcard string matcher: control sequencer and the cell chain.
// Depends on wsm_pkg and wsm_cell.
//
//   channel  dir  handshake              payload
//   s_*      in   s_tvalid / s_tready    s_tdata, s_tuser (kind)
//   m_*      out  m_tvalid / m_tready    m_tdata (match_start)
//   cfg_*    in   cfg_valid / cfg_ready  cfg_data (pattern_length)
//
// Pattern writes, restarts and ignored transactions keep the sequencer idle. A text
// symbol goes through the align and compare states (L = pattern length): the probe
// copy of the window walks 64 - L cells down the chain to align with the pattern.
// A match waits in the compare state while the output register is still full.
// rst is synchronous: window cleared, count zero, pattern length one.
module wildcard_string_matcher (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [wsm_pkg::S_TDATA_W-1:0] s_tdata,  // [5:0] pattern_index, [10:6] symbol
  input  logic [wsm_pkg::KIND_W-1:0]    s_tuser,  // [1:0] kind
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [wsm_pkg::M_TDATA_W-1:0] m_tdata,  // [20:0] match_start
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wsm_pkg::LEN_W-1:0]     cfg_data
);
  import wsm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_CHECK
  } state_t;

  state_t              state;
  logic [LEN_W-1:0]    pattern_length;
  logic [LEN_W-1:0]    len_eff;
  logic [COUNT_W-1:0]  text_count;
  logic [COUNT_W-1:0]  count_inc;
  logic [IDX_W-1:0]    remaining;
  logic                count_ok;
  logic [COUNT_W-1:0]  match_start;

  logic                accept;
  logic [KIND_W-1:0]   kind;
  logic [IDX_W-1:0]    pattern_index;
  logic [SYM_W-1:0]    symbol;
  logic                text_go;
  logic                all_hit;
  logic                out_free;
  logic                emit;

  cell_ctrl_t          ctrl;
  logic [SYM_W-1:0]    win   [PATTERN_MAX];
  logic [SYM_W-1:0]    probe [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] hits;

  assign kind          = s_tuser;
  assign pattern_index = s_tdata[IDX_W-1:0];
  assign symbol        = s_tdata[IDX_W +: SYM_W];

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign text_go   = accept && (kind == KIND_TEXT) && (text_count < TEXT_MAX);
  assign count_inc = text_count + COUNT_W'(1);
  assign out_free  = !m_tvalid || m_tready;
  assign all_hit   = &hits;
  assign emit      = (state == ST_CHECK) && count_ok && all_hit && out_free;

  always_comb begin
    priority if (pattern_length == '0) begin
      len_eff = LEN_MIN;
    end else if (pattern_length > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = pattern_length;
    end
  end

  assign match_start = text_count - COUNT_W'(len_eff) + COUNT_W'(1);

  assign ctrl.text_load   = text_go;
  assign ctrl.probe_shift = (state == ST_ALIGN) && (remaining != '0);

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic [SYM_W-1:0] win_in;
    logic [SYM_W-1:0] probe_in;

    if (i == PATTERN_MAX - 1) begin : g_tail
      assign win_in   = symbol;
      assign probe_in = SYM_WILD;
    end else begin : g_body
      assign win_in   = win[i+1];
      assign probe_in = probe[i+1];
    end

    wsm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .pat_we    (accept && (kind == KIND_PATTERN) && (pattern_index == IDX_W'(i))),
      .pat_wdata (symbol),
      .win_in    (win_in),
      .win_out   (win[i]),
      .probe_in  (probe_in),
      .probe_out (probe[i]),
      .active    (LEN_W'(i) < len_eff),
      .hit       (hits[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      pattern_length <= LEN_MIN;
      text_count     <= '0;
      remaining      <= '0;
      count_ok       <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pattern_length <= cfg_data;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
        m_tdata  <= M_TDATA_W'(match_start);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (kind == KIND_RESTART)) begin
            text_count <= '0;
          end
          if (text_go) begin
            text_count <= count_inc;
            count_ok   <= (count_inc >= COUNT_W'(len_eff));
            remaining  <= IDX_W'(LEN_MAX - len_eff);
            state      <= ST_ALIGN;
          end
        end
        ST_ALIGN: begin
          if (remaining == '0) begin
            state <= ST_CHECK;
          end else begin
            remaining <= remaining - IDX_W'(1);
          end
        end
        ST_CHECK: begin
          if (!(count_ok && all_hit) || out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
